// ===== rtl/core/lfs_pkg.sv =====
// Shared types, register indexes and constants for the link fallback supervisor.
package lfs_pkg;

    // Highest scan channel; a step past it wraps to channel 1
    localparam logic [3:0] MAX_CHANNEL = 4'd13;
    localparam logic [3:0] FIRST_CHANNEL = 4'd1;

    // Configuration register indexes
    localparam logic [2:0] CFG_IS_HUB       = 3'd0;
    localparam logic [2:0] CFG_MONITOR      = 3'd1;
    localparam logic [2:0] CFG_JOIN_TO      = 3'd2;
    localparam logic [2:0] CFG_VALIDATE_TO  = 3'd3;
    localparam logic [2:0] CFG_CHECK_PERIOD = 3'd4;
    localparam logic [2:0] CFG_SCAN_PERIOD  = 3'd5;
    localparam logic [2:0] CFG_RETRY_PERIOD = 3'd6;

    // Configuration reset values
    localparam logic [31:0] RST_JOIN_TO      = 32'd15000;
    localparam logic [31:0] RST_VALIDATE_TO  = 32'd10000;
    localparam logic [31:0] RST_CHECK_PERIOD = 32'd2000;
    localparam logic [31:0] RST_SCAN_PERIOD  = 32'd500;
    localparam logic [31:0] RST_RETRY_PERIOD = 32'd60000;

    // Input word kinds
    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_FAIL  = 2'd1,
        ACT_START = 2'd2
    } t_action;

    // Link modes
    typedef enum logic [1:0] {
        MODE_JOINING    = 2'd0,
        MODE_VALIDATING = 2'd1,
        MODE_CONNECTED  = 2'd2,
        MODE_FALLBACK   = 2'd3
    } t_mode;

    // Configuration register set
    typedef struct packed {
        logic        is_hub;
        logic        monitor_present;
        logic [31:0] join_timeout_ms;
        logic [31:0] validate_timeout_ms;
        logic [31:0] check_period_ms;
        logic [31:0] scan_period_ms;
        logic [31:0] retry_period_ms;
    } t_cfg;

    // One input word
    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] now_ms;
        logic        radio_linked;
        logic        internet_ok;
    } t_item;

    // One result word
    typedef struct packed {
        logic [1:0] link_mode;
        logic [3:0] scan_channel;
        logic       start_join;
        logic       drop_join;
        logic       tune_channel;
        logic       entered_fallback;
    } t_res;

endpackage

// ===== rtl/core/lfs_cfg_regs.sv =====
// Configuration register file of the link fallback supervisor.
module lfs_cfg_regs
    import lfs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr,
    input  logic [2:0]  i_index,
    input  logic [31:0] i_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    // Register writes; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.is_hub              <= 1'b0;
            r_cfg.monitor_present     <= 1'b0;
            r_cfg.join_timeout_ms     <= RST_JOIN_TO;
            r_cfg.validate_timeout_ms <= RST_VALIDATE_TO;
            r_cfg.check_period_ms     <= RST_CHECK_PERIOD;
            r_cfg.scan_period_ms      <= RST_SCAN_PERIOD;
            r_cfg.retry_period_ms     <= RST_RETRY_PERIOD;
        end else if (i_wr) begin
            case (i_index)
                CFG_IS_HUB:       r_cfg.is_hub              <= i_data[0];
                CFG_MONITOR:      r_cfg.monitor_present     <= i_data[0];
                CFG_JOIN_TO:      r_cfg.join_timeout_ms     <= i_data;
                CFG_VALIDATE_TO:  r_cfg.validate_timeout_ms <= i_data;
                CFG_CHECK_PERIOD: r_cfg.check_period_ms     <= i_data;
                CFG_SCAN_PERIOD:  r_cfg.scan_period_ms      <= i_data;
                CFG_RETRY_PERIOD: r_cfg.retry_period_ms     <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/lfs_core.sv =====
// Mode state, timestamps and channel with the single-pass next-state logic.
module lfs_core
    import lfs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_step,
    input  t_item i_item,
    input  t_cfg  i_cfg,
    output t_res  o_res
);

    t_mode       r_mode, n_mode;
    logic [31:0] r_phase_start, n_phase_start;
    logic [31:0] r_last_check, n_last_check;
    logic [31:0] r_last_scan, n_last_scan;
    logic [3:0]  r_channel, n_channel;

    logic [31:0] el_phase, el_check, el_scan;
    logic [4:0]  ch_inc;
    logic        inet, go_fb, go_jn;
    logic        st_join, st_drop, st_tune, st_entered;

    // Wrapping elapsed times and the next scan channel
    assign el_phase = i_item.now_ms - r_phase_start;
    assign el_check = i_item.now_ms - r_last_check;
    assign el_scan  = i_item.now_ms - r_last_scan;
    assign ch_inc   = {1'b0, r_channel} + 5'd1;
    assign inet     = i_item.internet_ok & i_cfg.monitor_present;

    // Decide the mode change for this word
    always_comb begin
        n_mode        = r_mode;
        n_phase_start = r_phase_start;
        n_last_check  = r_last_check;
        n_last_scan   = r_last_scan;
        n_channel     = r_channel;
        go_fb         = 1'b0;
        go_jn         = 1'b0;
        st_drop       = 1'b0;
        st_tune       = 1'b0;
        case (i_item.action)
            ACT_TICK: begin
                case (r_mode)
                    MODE_JOINING: begin
                        if (i_item.radio_linked) begin
                            n_mode        = MODE_VALIDATING;
                            n_phase_start = i_item.now_ms;
                        end else if (el_phase > i_cfg.join_timeout_ms) begin
                            go_fb = 1'b1;
                        end
                    end
                    MODE_VALIDATING: begin
                        if (inet) begin
                            n_mode = MODE_CONNECTED;
                        end else if (el_phase > i_cfg.validate_timeout_ms ||
                                     !i_item.radio_linked) begin
                            go_fb = 1'b1;
                        end
                    end
                    MODE_CONNECTED: begin
                        if (el_check >= i_cfg.check_period_ms) begin
                            n_last_check = i_item.now_ms;
                            if (!i_item.radio_linked ||
                                (i_cfg.monitor_present && !i_item.internet_ok)) begin
                                go_fb = 1'b1;
                            end
                        end
                    end
                    default: begin
                        // fallback: channel scan, then the rejoin timer
                        if (el_scan >= i_cfg.scan_period_ms) begin
                            n_last_scan = i_item.now_ms;
                            if (!i_cfg.is_hub) begin
                                n_channel = (ch_inc > {1'b0, MAX_CHANNEL}) ?
                                            FIRST_CHANNEL : ch_inc[3:0];
                                st_tune   = 1'b1;
                            end
                        end
                        if (el_check >= i_cfg.retry_period_ms) begin
                            n_last_check = i_item.now_ms;
                            go_jn        = 1'b1;
                        end
                    end
                endcase
            end
            ACT_FAIL: begin
                if (r_mode == MODE_CONNECTED) begin
                    go_fb = 1'b1;
                end
            end
            ACT_START: begin
                st_drop = !i_cfg.is_hub;
                go_jn   = 1'b1;
            end
            default: ;
        endcase

        // enter fallback
        st_entered = 1'b0;
        if (go_fb) begin
            st_entered   = (r_mode != MODE_FALLBACK);
            n_mode       = MODE_FALLBACK;
            n_last_check = i_item.now_ms;
            n_last_scan  = i_item.now_ms;
            st_drop      = !i_cfg.is_hub;
        end

        // start a join
        st_join = go_jn;
        if (go_jn) begin
            n_mode        = MODE_JOINING;
            n_phase_start = i_item.now_ms;
        end
    end

    // State registers advance once per processed word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_JOINING;
            r_phase_start <= '0;
            r_last_check  <= '0;
            r_last_scan   <= '0;
            r_channel     <= FIRST_CHANNEL;
        end else if (i_step) begin
            r_mode        <= n_mode;
            r_phase_start <= n_phase_start;
            r_last_check  <= n_last_check;
            r_last_scan   <= n_last_scan;
            r_channel     <= n_channel;
        end
    end

    // Result of the word being processed
    assign o_res.link_mode        = n_mode;
    assign o_res.scan_channel     = n_channel;
    assign o_res.start_join       = st_join;
    assign o_res.drop_join        = st_drop;
    assign o_res.tune_channel     = st_tune;
    assign o_res.entered_fallback = st_entered;

    // Channel stays within the scan range
    a_channel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_channel != 4'd0) && (r_channel <= MAX_CHANNEL))
        else $error("scan channel out of range");

    // A hub never disconnects or retunes
    a_hub_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_cfg.is_hub) |-> (!st_drop && !st_tune))
        else $error("hub issued drop or tune");

    // Entering fallback lands in fallback mode
    a_entered_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && st_entered) |=> (r_mode == MODE_FALLBACK))
        else $error("entered fallback but mode differs");

    // A join strobe leaves the block joining with a fresh phase mark
    a_join_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && st_join) |=>
        (r_mode == MODE_JOINING && r_phase_start == $past(i_item.now_ms)))
        else $error("join strobe without join state");

    // Retune only happens from fallback
    a_tune_fallback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && st_tune) |-> (r_mode == MODE_FALLBACK))
        else $error("retune outside fallback");

endmodule

// ===== rtl/core/link_fallback_supervisor.sv =====
// Top level of the link fallback supervisor: stream ports, input and result registers.
//
// Usage:
//   Slave stream (i_s_axis_*) carries one event word: tuser is the action
//   (tick, internet failure report, start command), tdata the timestamp and
//   the link and internet flags. Master stream (o_m_axis_*) returns exactly
//   one result word per event: mode, scan channel and command strobes.
//   Configuration is a separate write channel (i_cfg_valid/o_cfg_ready,
//   index and 32-bit data); it is always ready; it must be written while idle, which the block does not enforce.
//   An accepted word passes the input register, then the result register.
//   Throughput: one word per cycle while the receiver takes results; the
//   mode and timestamp registers are updated in the same cycle as the result
//   register, so the next word sees the new state at once.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more word; after that tready drops until the
//   result is taken.
//   Reset (synchronous, active low) returns the registers to their defaults,
//   the mode to joining, channel to 1 and empties both stages.
module link_fallback_supervisor
    import lfs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // event stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,  // now_ms[31:0], radio_linked, internet_ok, zero pad
    input  logic [1:0]  i_s_axis_tuser,  // action[1:0]
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,  // link_mode[1:0], scan_channel[5:2], start_join,
                                         // drop_join, tune_channel, entered_fallback, zero pad
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_cfg  cfg;
    t_item r_item;
    logic  r_in_valid;
    t_res  r_res;
    logic  r_out_valid;
    t_res  res;
    logic  out_free, step;

    assign o_cfg_ready = 1'b1;

    lfs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // Handshake: process the held word when the result slot is free
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign step            = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_item.action       <= i_s_axis_tuser;
            r_item.now_ms       <= i_s_axis_tdata[31:0];
            r_item.radio_linked <= i_s_axis_tdata[32];
            r_item.internet_ok  <= i_s_axis_tdata[33];
        end
    end

    lfs_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_item),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0,
                              r_res.entered_fallback,
                              r_res.tune_channel,
                              r_res.drop_join,
                              r_res.start_join,
                              r_res.scan_channel,
                              r_res.link_mode};

endmodule
